[hw/rtl/quadrature_decoder_gated_velocity_top_assert.svh]
// Assertion macros for the quadrature decoder with gated velocity.
`ifndef QUADRATURE_DECODER_GATED_VELOCITY_TOP_ASSERT_SVH
`define QUADRATURE_DECODER_GATED_VELOCITY_TOP_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define QDGV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qdgv: same-cycle check failed");

// The antecedent implies the consequent in the following cycle.
`define QDGV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qdgv: next-cycle check failed");

`endif

[hw/rtl/qdgv_pkg.sv]
// Shared types and constants of the quadrature decoder with gated velocity.
package qdgv_pkg;

	// Request kinds as they arrive on the input stream.
	localparam logic [2:0] REQ_EDGE  = 3'd0;
	localparam logic [2:0] REQ_TICK  = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_SET   = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SHORT_GATE  = 3'd0;
	localparam logic [2:0] CFG_LONG_GATE   = 3'd1;
	localparam logic [2:0] CFG_SLOW_LIMIT  = 3'd2;
	localparam logic [2:0] CFG_FAST_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_SHORT_SCALE = 3'd4;
	localparam logic [2:0] CFG_LONG_SCALE  = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [2:0] {
		OP_EDGE,
		OP_TICK,
		OP_READ,
		OP_SET,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// Classified command passed from the front end to the execution unit.
	typedef struct packed {
		op_t         op;
		logic        up;
		logic [31:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	typedef struct packed {
		logic issue;
		op_t  op;
		logic long_mode;
	} bstat_t;

endpackage

[hw/rtl/quadrature_decoder_gated_velocity_top.sv]
// Top level of the four-times quadrature decoder with gated velocity.
//
//  Channel  Direction  Signals                                   Moves
//  s_*      in         s_tvalid s_tready s_tdata[39:0] s_tuser   one request
//  m_*      out        m_tvalid m_tready m_tdata[71:0]           one result per request
//  cfg_*    in         cfg_we cfg_index[2:0] cfg_wdata[14:0]     register write
//
// Sustained rate is one request per clock while m_tready is high; every request
// updates the state in the execution unit. An accepted request enters the queue
// and, once the result register is free, moves on into it. Reset clears the
// queue and decoder state and loads the register defaults. A two-entry queue
// holds requests while m_tready is low; s_tready drops once it is full.
`include "quadrature_decoder_gated_velocity_top_assert.svh"

module quadrature_decoder_gated_velocity_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// edge_pin[0], pin_a[1], pin_b[2], load_value[34:3], zero fill above
	input  logic [39:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// position_count[31:0], filtered_velocity[47:32], latched_gate_count[63:48],
	// long_gate_active[64], zero fill above
	output logic [71:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_wdata
);
	import qdgv_pkg::*;

	logic   push, pop;
	cmd_t   push_cmd, pop_cmd;
	qstat_t qstat;
	bstat_t bstat;

	logic [31:0] position_count;
	logic [15:0] filtered_velocity, latched_gate_count;
	logic        long_gate_active;

	qdgv_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req_type   (s_tuser),
		.edge_pin   (s_tdata[0]),
		.pin_a      (s_tdata[1]),
		.pin_b      (s_tdata[2]),
		.load_value (s_tdata[34:3]),
		.qstat      (qstat),
		.push       (push),
		.cmd        (push_cmd)
	);

	qdgv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	qdgv_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.q_empty            (qstat.empty),
		.cmd                (pop_cmd),
		.pop                (pop),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.position_count     (position_count),
		.filtered_velocity  (filtered_velocity),
		.latched_gate_count (latched_gate_count),
		.long_gate_active   (long_gate_active),
		.stat               (bstat)
	);

	assign m_tdata = {7'd0, long_gate_active, latched_gate_count,
		filtered_velocity, position_count};

	// A command issues only when the queue holds one.
	`QDGV_ASSERT_NOW(a_issue_from_queue, bstat.issue, qstat.count != 2'd0)
	// Only a velocity read may change the gate mode.
	`QDGV_ASSERT_NEXT(a_mode_on_read_only, !(bstat.issue && bstat.op == OP_READ),
		$stable(bstat.long_mode))
	// An issued command always leaves a result waiting on the output.
	`QDGV_ASSERT_NEXT(a_issue_gives_result, bstat.issue, m_tvalid)

endmodule

[hw/rtl/qdgv_front.sv]
// Front end: accepts requests and classifies them into commands.
module qdgv_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [2:0]         req_type,
	input  logic               edge_pin,
	input  logic               pin_a,
	input  logic               pin_b,
	input  logic [31:0]        load_value,
	input  qdgv_pkg::qstat_t   qstat,
	output logic               push,
	output qdgv_pkg::cmd_t     cmd
);
	import qdgv_pkg::*;

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cmd.load_value = load_value;
		// An A edge counts up when the levels match, a B edge when they differ.
		cmd.up = edge_pin ? (pin_a ^ pin_b) : ~(pin_a ^ pin_b);
		unique case (req_type)
			REQ_EDGE:  cmd.op = OP_EDGE;
			REQ_TICK:  cmd.op = OP_TICK;
			REQ_READ:  cmd.op = OP_READ;
			REQ_SET:   cmd.op = OP_SET;
			REQ_CLEAR: cmd.op = OP_CLEAR;
			default:   cmd.op = OP_NOP;
		endcase
	end

endmodule

[hw/rtl/qdgv_queue.sv]
// Two-entry command queue between the front end and the execution unit.
module qdgv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qdgv_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output qdgv_pkg::cmd_t   pop_cmd,
	output qdgv_pkg::qstat_t qstat
);
	import qdgv_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	assign pop_cmd     = mem_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

endmodule

[hw/rtl/qdgv_back.sv]
// Execution unit: counters, gate timer, velocity filter and result register.
module qdgv_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qdgv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qdgv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                q_empty,
	input  qdgv_pkg::cmd_t                      cmd,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [31:0]                         position_count,
	output logic [15:0]                         filtered_velocity,
	output logic [15:0]                         latched_gate_count,
	output logic                                long_gate_active,
	output qdgv_pkg::bstat_t                    stat
);
	import qdgv_pkg::*;

	logic [7:0]  short_gate_q, long_gate_q;
	logic [14:0] slow_limit_q, fast_limit_q;
	logic [6:0]  short_scale_q, long_scale_q;

	// The state registers double as the result register: they change only
	// when a command issues, and a command issues only into a free result slot.
	logic [31:0] total_q;
	logic [15:0] gate_cnt_q;
	logic [15:0] raw_q;
	logic [15:0] vel_q;
	logic [7:0]  timer_q;
	logic        long_q;
	logic        valid_q;

	logic [31:0] total_d;
	logic [15:0] gate_cnt_d, raw_d, vel_d;
	logic [7:0]  timer_d, tick_len, timer_inc;
	logic        long_d;

	logic signed [23:0] rv_x, sc_x, prod, prod_q4, pf_x, pf_q4, vsum;
	logic signed [16:0] rv17, lim17;
	logic [14:0]        lim;
	logic [6:0]         scale;

	assign pop = !q_empty && (!valid_q || m_tready);

	always_comb begin
		lim   = long_q ? fast_limit_q : slow_limit_q;
		scale = long_q ? long_scale_q : short_scale_q;
		rv17  = $signed({raw_q[15], raw_q});
		lim17 = $signed({2'b00, lim});
		rv_x  = $signed({{8{raw_q[15]}}, raw_q});
		sc_x  = $signed({17'd0, scale});
		prod  = rv_x * sc_x;
		// Quarter with truncation toward zero: bias negative values by three.
		prod_q4 = (prod + (prod[23] ? 24'sd3 : 24'sd0)) >>> 2;
		pf_x    = $signed({{8{vel_q[15]}}, vel_q});
		pf_q4   = (pf_x + (pf_x[23] ? 24'sd3 : 24'sd0)) >>> 2;
		vsum    = prod_q4 + pf_q4;
		tick_len  = long_q ? long_gate_q : short_gate_q;
		timer_inc = timer_q + 8'd1;
	end

	always_comb begin
		total_d    = total_q;
		gate_cnt_d = gate_cnt_q;
		raw_d      = raw_q;
		vel_d      = vel_q;
		timer_d    = timer_q;
		long_d     = long_q;
		unique case (cmd.op)
			OP_EDGE: begin
				total_d    = cmd.up ? total_q + 32'd1 : total_q - 32'd1;
				gate_cnt_d = cmd.up ? gate_cnt_q + 16'd1 : gate_cnt_q - 16'd1;
			end
			OP_TICK: begin
				if (timer_inc == tick_len) begin
					raw_d      = gate_cnt_q;
					gate_cnt_d = 16'd0;
					timer_d    = 8'd0;
				end else begin
					timer_d = timer_inc;
				end
			end
			OP_READ: begin
				if (!long_q) begin
					if (rv17 < lim17 && rv17 > -lim17) long_d = 1'b1;
				end else begin
					if (rv17 > lim17 || rv17 < -lim17) long_d = 1'b0;
				end
				if (vsum > 24'sd32767)       vel_d = 16'h7FFF;
				else if (vsum < -24'sd32768) vel_d = 16'h8000;
				else                         vel_d = vsum[15:0];
			end
			OP_SET: begin
				total_d = cmd.load_value;
			end
			OP_CLEAR: begin
				total_d    = 32'd0;
				gate_cnt_d = 16'd0;
				raw_d      = 16'd0;
				timer_d    = 8'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_gate_q  <= 8'd24;
			long_gate_q   <= 8'd122;
			slow_limit_q  <= 15'd5;
			fast_limit_q  <= 15'd80;
			short_scale_q <= 7'd60;
			long_scale_q  <= 7'd12;
			total_q       <= 32'd0;
			gate_cnt_q    <= 16'd0;
			raw_q         <= 16'd0;
			vel_q         <= 16'd0;
			timer_q       <= 8'd0;
			long_q        <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHORT_GATE:  short_gate_q  <= cfg_wdata[7:0];
					CFG_LONG_GATE:   long_gate_q   <= cfg_wdata[7:0];
					CFG_SLOW_LIMIT:  slow_limit_q  <= cfg_wdata;
					CFG_FAST_LIMIT:  fast_limit_q  <= cfg_wdata;
					CFG_SHORT_SCALE: short_scale_q <= cfg_wdata[6:0];
					CFG_LONG_SCALE:  long_scale_q  <= cfg_wdata[6:0];
					default: begin
					end
				endcase
			end
			if (pop) begin
				total_q    <= total_d;
				gate_cnt_q <= gate_cnt_d;
				raw_q      <= raw_d;
				vel_q      <= vel_d;
				timer_q    <= timer_d;
				long_q     <= long_d;
				valid_q    <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid           = valid_q;
	assign position_count     = total_q;
	assign filtered_velocity  = vel_q;
	assign latched_gate_count = raw_q;
	assign long_gate_active   = long_q;

	assign stat.issue     = pop;
	assign stat.op        = cmd.op;
	assign stat.long_mode = long_q;

endmodule

[tb/quadrature_decoder_gated_velocity_top_tb.sv]
// Testbench of the quadrature decoder: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module quadrature_decoder_gated_velocity_top_tb;
	import qdgv_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [2:0]  kind;
		logic        edge_pin;
		logic        pin_a;
		logic        pin_b;
		logic [31:0] load_value;
	} request_t;

	typedef struct {
		logic [31:0] position;
		logic [15:0] velocity;
		logic [15:0] gate_count;
		logic        long_gate;
	} readout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = REQ_EDGE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_SHORT_GATE;
	logic [14:0] cfg_wdata = '0;

	// Predictor copy of the registers and of the decoder state.
	logic [7:0]  short_gate_len = 8'd24;
	logic [7:0]  long_gate_len = 8'd122;
	logic [14:0] slow_lim = 15'd5;
	logic [14:0] fast_lim = 15'd80;
	logic [6:0]  short_gain = 7'd60;
	logic [6:0]  long_gain = 7'd12;
	logic [31:0] pos_total = '0;
	logic [15:0] gate_sum = '0;
	logic [15:0] rate_latched = '0;
	logic [15:0] filt_velocity = '0;
	logic [7:0]  gate_timer = '0;
	logic        long_gate = 1'b0;

	readout_t expected_readouts[$];
	int       failures = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	bit       hold_request = 1'b0;
	int       hold_left = 0;
	int       quiet_cycles = 0;
	// Levels the encoder pins had after the last edge we sent.
	bit       lvl_a = 1'b0;
	bit       lvl_b = 1'b0;
	bit       heading_up = 1'b1;

	quadrature_decoder_gated_velocity_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic void predict_request(input request_t r);
		readout_t   now;
		logic       up;
		logic [7:0] span;
		int         rv;
		int         lim;
		int         gain;
		int         prev;
		int         v;
		case (r.kind)
			REQ_EDGE: begin
				up = r.edge_pin ? (r.pin_a != r.pin_b) : (r.pin_a == r.pin_b);
				pos_total = up ? pos_total + 32'd1 : pos_total - 32'd1;
				gate_sum = up ? gate_sum + 16'd1 : gate_sum - 16'd1;
			end
			REQ_TICK: begin
				span = long_gate ? long_gate_len : short_gate_len;
				gate_timer = gate_timer + 8'd1;
				if (gate_timer == span) begin
					rate_latched = gate_sum;
					gate_sum = '0;
					gate_timer = '0;
				end
			end
			REQ_READ: begin
				rv = $signed(rate_latched);
				prev = $signed(filt_velocity);
				// The scale comes from the mode in force before this read switches it.
				if (!long_gate) begin
					lim = slow_lim;
					gain = short_gain;
					if (rv < lim && rv > -lim)
						long_gate = 1'b1;
				end else begin
					lim = fast_lim;
					gain = long_gain;
					if (rv > lim || rv < -lim)
						long_gate = 1'b0;
				end
				v = (rv * gain) / 4 + prev / 4;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				filt_velocity = v[15:0];
			end
			REQ_SET: pos_total = r.load_value;
			REQ_CLEAR: begin
				pos_total = '0;
				gate_sum = '0;
				rate_latched = '0;
				gate_timer = '0;
			end
			default: ;
		endcase
		now.position = pos_total;
		now.velocity = filt_velocity;
		now.gate_count = rate_latched;
		now.long_gate = long_gate;
		expected_readouts.push_back(now);
	endfunction

	task automatic check_result(input logic [71:0] d);
		readout_t want;
		if (expected_readouts.size() == 0) begin
			$error("result with no request pending: %h", d);
			failures++;
		end else begin
			want = expected_readouts.pop_front();
			if (d[31:0] !== want.position) begin
				$error("position_count: expected %0d, got %0d",
					$signed(want.position), $signed(d[31:0]));
				failures++;
			end
			if (d[47:32] !== want.velocity) begin
				$error("filtered_velocity: expected %0d, got %0d",
					$signed(want.velocity), $signed(d[47:32]));
				failures++;
			end
			if (d[63:48] !== want.gate_count) begin
				$error("latched_gate_count: expected %0d, got %0d",
					$signed(want.gate_count), $signed(d[63:48]));
				failures++;
			end
			if (d[64] !== want.long_gate) begin
				$error("long_gate_active: expected %0b, got %0b", want.long_gate, d[64]);
				failures++;
			end
		end
	endtask

	// Result side: checks each accepted result and drives m_tready, with a
	// long hold-off when one is requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic request_t make_request(input logic [2:0] kind);
		request_t r;
		r.kind = kind;
		r.edge_pin = 1'($urandom_range(1));
		r.pin_a = 1'($urandom_range(1));
		r.pin_b = 1'($urandom_range(1));
		r.load_value = $urandom();
		return r;
	endfunction

	// Next edge of a clean quadrature sequence in the given direction.
	function automatic request_t next_edge(input bit up);
		request_t r;
		r = make_request(REQ_EDGE);
		r.edge_pin = up ? (lvl_a == lvl_b) : (lvl_a != lvl_b);
		if (r.edge_pin)
			lvl_b = !lvl_b;
		else
			lvl_a = !lvl_a;
		r.pin_a = lvl_a;
		r.pin_b = lvl_b;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			r = next_edge(heading_up);
		end else if (pick < 55) begin
			// Glitch: an edge with arbitrary levels.
			r = make_request(REQ_EDGE);
			lvl_a = r.pin_a;
			lvl_b = r.pin_b;
		end else if (pick < 78) begin
			r = make_request(REQ_TICK);
		end else if (pick < 89) begin
			r = make_request(REQ_READ);
		end else if (pick < 93) begin
			r = make_request(REQ_SET);
		end else if (pick < 97) begin
			r = make_request(REQ_CLEAR);
		end else begin
			r = make_request(3'($urandom_range(7, REQ_CLEAR + 1)));
		end
		if ($urandom_range(99) < 3)
			heading_up = !heading_up;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {5'd0, r.load_value, r.pin_b, r.pin_a, r.edge_pin};
		do @(posedge clk); while (!s_tready);
		predict_request(r);
	endtask

	task automatic send_motion(input int count, input bit up);
		repeat (count) send_request(next_edge(up));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[14:0];
		@(posedge clk);
		case (idx)
			CFG_SHORT_GATE: short_gate_len = value[7:0];
			CFG_LONG_GATE: long_gate_len = value[7:0];
			CFG_SLOW_LIMIT: slow_lim = value[14:0];
			CFG_FAST_LIMIT: fast_lim = value[14:0];
			CFG_SHORT_SCALE: short_gain = value[6:0];
			CFG_LONG_SCALE: long_gain = value[6:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int sg, input int lg, input int sl, input int fl,
			input int ss, input int ls);
		wait_idle();
		write_reg(CFG_SHORT_GATE, sg);
		write_reg(CFG_LONG_GATE, lg);
		write_reg(CFG_SLOW_LIMIT, sl);
		write_reg(CFG_FAST_LIMIT, fl);
		write_reg(CFG_SHORT_SCALE, ss);
		write_reg(CFG_LONG_SCALE, ls);
		cfg_we <= 1'b0;
	endtask

	task automatic test_request_kinds();
		request_t r;
		for (int e = 0; e < 2; e++)
			for (int a = 0; a < 2; a++)
				for (int b = 0; b < 2; b++) begin
					r = make_request(REQ_EDGE);
					r.edge_pin = 1'(e);
					r.pin_a = 1'(a);
					r.pin_b = 1'(b);
					send_request(r);
				end
		// Position count wraps in both directions.
		r = make_request(REQ_SET);
		r.load_value = 32'h7FFF_FFFF;
		send_request(r);
		r = make_request(REQ_EDGE);
		r.edge_pin = 1'b0;
		r.pin_a = 1'b1;
		r.pin_b = 1'b1;
		send_request(r);
		r = make_request(REQ_SET);
		r.load_value = 32'h8000_0000;
		send_request(r);
		r = make_request(REQ_EDGE);
		r.edge_pin = 1'b0;
		r.pin_a = 1'b1;
		r.pin_b = 1'b0;
		send_request(r);
		for (int k = REQ_CLEAR + 1; k < 8; k++)
			send_request(make_request(3'(k)));
		send_request(make_request(REQ_TICK));
		send_request(make_request(REQ_READ));
		send_request(make_request(REQ_READ));
		send_request(make_request(REQ_CLEAR));
	endtask

	// With a gate length of zero the gate closes only when the timer wraps.
	task automatic test_zero_gate_length();
		configure(0, 0, 5, 80, 60, 12);
		send_motion(5, 1'b1);
		repeat (256) send_request(make_request(REQ_TICK));
		send_request(make_request(REQ_READ));
	endtask

	// A large gate count with the full scale drives the filter into its upper
	// clamp within a few reads.
	task automatic test_velocity_saturation();
		configure(1, 1, 0, 0, 127, 127);
		send_request(make_request(REQ_CLEAR));
		send_motion(800, 1'b1);
		send_request(make_request(REQ_TICK));
		repeat (4) send_request(make_request(REQ_READ));
		send_motion(40, 1'b0);
		send_request(make_request(REQ_TICK));
		send_request(make_request(REQ_READ));
		send_request(make_request(REQ_READ));
	endtask

	task automatic test_register_extremes();
		configure(255, 255, 32767, 32767, 127, 127);
		repeat (20) send_request(random_request());
		configure(1, 1, 0, 0, 0, 0);
		repeat (20) send_request(random_request());
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		configure($urandom_range(1, 8), $urandom_range(2, 20), $urandom_range(0, 12),
			$urandom_range(0, 20), $urandom_range(0, 127), $urandom_range(0, 127));
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_request(random_request());
	endtask

	// The receiver stops for a long stretch while requests keep coming.
	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		repeat (40) send_request(random_request());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 7;
		recv_idle_pct = 88;
		test_request_kinds();
		test_zero_gate_length();
		test_velocity_saturation();
		test_register_extremes();
		test_random_traffic(7, 88, 40);
		test_random_traffic(88, 7, 40);
		test_random_traffic(0, 0, 40);
		test_receiver_stall();
		wait_idle();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
